>>> design/gss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gss_pkg;

    localparam int MAX_SIDE   = 63;
    localparam int ROWS       = MAX_SIDE + 1;
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int COORD_W    = 30;
    localparam int PRIME_W    = 16;
    localparam int NORM_W     = 33;
    localparam int PROD_W     = 46;
    localparam int NUM_W      = 47;
    localparam int COUNT_W    = 13;
    localparam int MOD_CNT_W  = 6;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_CROSS = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] CFG_BASE_RE = 2'd0;
    localparam logic [1:0] CFG_BASE_IM = 2'd1;
    localparam logic [1:0] CFG_SIDE    = 2'd2;

    // (r + step) mod n, with r < n and step <= n
    function automatic logic [NORM_W-1:0] add_mod(
        input logic [NORM_W-1:0] r,
        input logic [NORM_W-1:0] step,
        input logic [NORM_W-1:0] n
    );
        logic [NORM_W:0] sum;
        begin
            sum = {1'b0, r} + {1'b0, step};
            if (sum >= {1'b0, n})
            begin
                sum = sum - {1'b0, n};
            end
            add_mod = sum[NORM_W-1:0];
        end
    endfunction

    // (r - step) mod n, with r < n and step <= n
    function automatic logic [NORM_W-1:0] sub_mod(
        input logic [NORM_W-1:0] r,
        input logic [NORM_W-1:0] step,
        input logic [NORM_W-1:0] n
    );
        begin
            if (r >= step)
            begin
                sub_mod = r - step;
            end
            else
            begin
                sub_mod = r + (n - step);
            end
        end
    endfunction

endpackage

`default_nettype wire

>>> design/gss_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder, one numerator bit per cycle.
module gss_mod
    import gss_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [NORM_W-1:0] den,
    output logic                   done,
    output logic [NORM_W-1:0]      rem
);

    logic [NUM_W-1:0]     num_reg;
    logic [NORM_W-1:0]    rem_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [NORM_W:0]      shifted;
    logic [NORM_W-1:0]    rem_next;

    always_comb
    begin
        shifted = {rem_reg, num_reg[NUM_W-1]};
        if (shifted >= {1'b0, den})
        begin
            rem_next = NORM_W'(shifted - {1'b0, den});
        end
        else
        begin
            rem_next = shifted[NORM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MOD_CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MOD_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

>>> design/gaussian_segment_sieve.sv
`timescale 1ns / 1ps
`default_nettype none

// Segmented sieve over a square block of Gaussian integers.
// Input channel (in_valid/in_stall) carries one request: action, prime_re,
// prime_im, row_index. Output channel (out_valid/out_stall) returns one result
// per request: row_bits for a row read, cells_marked for a cross-off.
// Config channel (cfg_valid/cfg_ready, always ready) writes base_re, base_im
// and side; write only while the block is idle.
// Timing: the block works on one request at a time; in_stall is high while
// busy. A clear drops the valid bits at once. A cross-off runs six steps of
// the shared 16x30 multiplier, three passes of the bit-serial remainder unit
// (a start state and a wait state each), then per row a read, a read wait,
// a step per cell and a write of the row memory.
// A cell is a multiple when both parts of (X+Yi)(a-bi) vanish mod a^2+b^2;
// those residues are stepped incrementally across the block.
// Reset empties the block to all ones (per-row valid bits) and sets side 63.
// When out_stall holds the result, the next request is still taken; its
// result waits in the finish state until the output register frees.
module gaussian_segment_sieve
    import gss_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [PRIME_W-1:0] prime_re,
    input  wire logic [PRIME_W-1:0] prime_im,
    input  wire logic [IDX_W-1:0]   row_index,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [ROW_W-1:0]        row_bits,
    output logic [COUNT_W-1:0]      cells_marked,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [COORD_W-1:0] cfg_data
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MUL      = 4'd1;
    localparam logic [3:0] ST_MOD_GO   = 4'd2;
    localparam logic [3:0] ST_MOD_WAIT = 4'd3;
    localparam logic [3:0] ST_ROW_RD   = 4'd4;
    localparam logic [3:0] ST_ROW_WAIT = 4'd5;
    localparam logic [3:0] ST_CELL     = 4'd6;
    localparam logic [3:0] ST_ROW_WR   = 4'd7;
    localparam logic [3:0] ST_RD_WAIT  = 4'd8;
    localparam logic [3:0] ST_FIN      = 4'd9;

    logic [3:0]         state_reg;
    logic [COORD_W-1:0] base_re_reg;
    logic [COORD_W-1:0] base_im_reg;
    logic [IDX_W-1:0]   side_reg;

    logic [ROW_W-1:0]   mem [ROWS];
    logic [ROW_W-1:0]   mem_q;
    logic [ROWS-1:0]    valid_reg;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic [PRIME_W-1:0] a_reg;
    logic [PRIME_W-1:0] b_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [2:0]         mstep_reg;
    logic [1:0]         msel_reg;
    logic [NORM_W-1:0]  n_reg;
    logic [NUM_W-1:0]   s1_reg;
    logic [PROD_W-1:0]  p3_reg;
    logic [PROD_W-1:0]  p4_reg;
    logic [NORM_W-1:0]  m3_reg;
    logic [NORM_W-1:0]  r1_row_reg;
    logic [NORM_W-1:0]  r2_row_reg;
    logic [NORM_W-1:0]  r1_reg;
    logic [NORM_W-1:0]  r2_reg;
    logic [IDX_W-1:0]   u_reg;
    logic [IDX_W-1:0]   v_reg;
    logic [ROW_W-1:0]   line_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ROW_W-1:0]   res_bits_reg;

    logic               out_valid_reg;
    logic [ROW_W-1:0]   out_bits_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               accept;
    logic [PRIME_W-1:0] mop_a;
    logic [COORD_W-1:0] mop_b;
    logic [PROD_W-1:0]  prod;
    logic               mod_start;
    logic [NUM_W-1:0]   mod_num;
    logic               mod_done;
    logic [NORM_W-1:0]  mod_rem;
    logic [ROW_W-1:0]   side_mask;
    logic [ROW_W-1:0]   rd_row;
    logic               out_free;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign side_mask = {ROW_W{1'b1}} >> (IDX_W'(MAX_SIDE) - side_reg);
    assign rd_row    = valid_reg[u_reg] ? mem_q : {ROW_W{1'b1}};

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_re_reg <= '0;
            base_im_reg <= '0;
            side_reg    <= IDX_W'(MAX_SIDE);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_BASE_RE: base_re_reg <= cfg_data;
                CFG_BASE_IM: base_im_reg <= cfg_data;
                CFG_SIDE:    side_reg    <= cfg_data[IDX_W-1:0];
                default:     ;
            endcase
        end
    end

    // Shared multiplier: norm, a*x + b*y, a*y, b*x
    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin mop_a = a_reg; mop_b = COORD_W'(a_reg); end
            3'd1:    begin mop_a = b_reg; mop_b = COORD_W'(b_reg); end
            3'd2:    begin mop_a = a_reg; mop_b = base_re_reg;     end
            3'd3:    begin mop_a = b_reg; mop_b = base_im_reg;     end
            3'd4:    begin mop_a = a_reg; mop_b = base_im_reg;     end
            default: begin mop_a = b_reg; mop_b = base_re_reg;     end
        endcase
    end
    assign prod = PROD_W'(mop_a) * PROD_W'(mop_b);

    always_comb
    begin
        case (msel_reg)
            2'd0:    mod_num = s1_reg;
            2'd1:    mod_num = NUM_W'(p3_reg);
            default: mod_num = NUM_W'(p4_reg);
        endcase
    end
    assign mod_start = (state_reg == ST_MOD_GO);

    gss_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .num   (mod_num),
        .den   (n_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // Row memory, registered read
    assign rd_en   = (accept && action == ACT_READ) || (state_reg == ST_ROW_RD);
    assign rd_addr = (state_reg == ST_IDLE) ? row_index : u_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
        if (state_reg == ST_ROW_WR)
        begin
            mem[u_reg] <= line_reg;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (action == ACT_CLEAR)
                        begin
                            valid_reg <= '0;
                            state_reg <= ST_FIN;
                        end
                        else if (action == ACT_READ)
                        begin
                            state_reg <= ST_RD_WAIT;
                        end
                        else if (action == ACT_CROSS && prime_re != '0)
                        begin
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (mstep_reg == 3'd5)
                    begin
                        state_reg <= ST_MOD_GO;
                    end
                end
                ST_MOD_GO:
                begin
                    state_reg <= ST_MOD_WAIT;
                end
                ST_MOD_WAIT:
                begin
                    if (mod_done)
                    begin
                        state_reg <= (msel_reg == 2'd2) ? ST_ROW_RD : ST_MOD_GO;
                    end
                end
                ST_ROW_RD:
                begin
                    state_reg <= ST_ROW_WAIT;
                end
                ST_ROW_WAIT:
                begin
                    state_reg <= ST_CELL;
                end
                ST_CELL:
                begin
                    if (v_reg == side_reg)
                    begin
                        state_reg <= ST_ROW_WR;
                    end
                end
                ST_ROW_WR:
                begin
                    valid_reg[u_reg] <= 1'b1;
                    state_reg <= (u_reg == side_reg) ? ST_FIN : ST_ROW_RD;
                end
                ST_RD_WAIT:
                begin
                    state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                a_reg        <= prime_re;
                b_reg        <= prime_im;
                row_reg      <= row_index;
                mstep_reg    <= 3'd0;
                msel_reg     <= 2'd0;
                u_reg        <= '0;
                count_reg    <= '0;
                res_bits_reg <= '0;
            end
            ST_MUL:
            begin
                mstep_reg <= mstep_reg + 1'b1;
                case (mstep_reg)
                    3'd0:    n_reg  <= NORM_W'(prod);
                    3'd1:    n_reg  <= n_reg + NORM_W'(prod);
                    3'd2:    s1_reg <= NUM_W'(prod);
                    3'd3:    s1_reg <= s1_reg + NUM_W'(prod);
                    3'd4:    p3_reg <= prod;
                    default: p4_reg <= prod;
                endcase
            end
            ST_MOD_WAIT:
            begin
                if (mod_done)
                begin
                    msel_reg <= msel_reg + 1'b1;
                    case (msel_reg)
                        2'd0:    r1_row_reg <= mod_rem;
                        2'd1:    m3_reg     <= mod_rem;
                        default: r2_row_reg <= sub_mod(m3_reg, mod_rem, n_reg);
                    endcase
                end
            end
            ST_ROW_WAIT:
            begin
                line_reg <= rd_row;
                r1_reg   <= r1_row_reg;
                r2_reg   <= r2_row_reg;
                v_reg    <= '0;
            end
            ST_CELL:
            begin
                // drop the cell when both residues vanish
                if (r1_reg == '0 && r2_reg == '0)
                begin
                    line_reg[v_reg] <= 1'b0;
                    count_reg       <= count_reg + 1'b1;
                end
                r1_reg <= add_mod(r1_reg, NORM_W'(b_reg), n_reg);
                r2_reg <= add_mod(r2_reg, NORM_W'(a_reg), n_reg);
                v_reg  <= v_reg + 1'b1;
            end
            ST_ROW_WR:
            begin
                r1_row_reg <= add_mod(r1_row_reg, NORM_W'(a_reg), n_reg);
                r2_row_reg <= sub_mod(r2_row_reg, NORM_W'(b_reg), n_reg);
                u_reg      <= u_reg + 1'b1;
            end
            ST_RD_WAIT:
            begin
                if (row_reg <= side_reg)
                begin
                    res_bits_reg <= (valid_reg[row_reg] ? mem_q : {ROW_W{1'b1}})
                                    & side_mask;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_FIN && out_free)
        begin
            out_bits_reg  <= res_bits_reg;
            out_count_reg <= count_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign row_bits     = out_bits_reg;
    assign cells_marked = out_count_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cells_marked <= COUNT_W'(ROWS * ROWS))
        else $error("cells_marked beyond block size");

    a_cell_in_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CELL |-> (v_reg <= side_reg && u_reg <= side_reg))
        else $error("cell walk left the block");

    a_clear_drops_rows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_CLEAR) |=> valid_reg == '0)
        else $error("clear did not drop row valid bits");
`endif

endmodule

`default_nettype wire
